>>> hdl/progress_stall_watchdog_assert.svh
// Assertion macros for the progress stall watchdog.
// Taken in by the top level; no other dependencies.
`ifndef PROGRESS_STALL_WATCHDOG_ASSERT_SVH
`define PROGRESS_STALL_WATCHDOG_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PSW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/psw_pkg.sv
// Shared types and constants of the progress stall watchdog.
// No dependencies; used by every other file of the block but the assertion header.
package psw_pkg;

    // Significant bits of sequence and round numbers (16 to 64)
    localparam int SEQ_BITS   = 64;
    // Fixed port widths
    localparam int SEQ_FLD_W  = 64;
    localparam int TIME_W     = 32;
    localparam int CACHE_W    = 32;
    localparam int CFG_W      = 16;
    localparam int KICK_W     = 16;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BEHIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_KICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_EN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TELEM_EN    = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_MIN_BEHIND = 16'd10;
    localparam logic [CFG_W-1:0] RST_STUCK_THR  = 16'd300;
    localparam logic [CFG_W-1:0] RST_HARD_KICKS = 16'd5;
    localparam logic             RST_KICK_EN    = 1'b1;
    localparam logic             RST_TELEM_EN   = 1'b0;

    localparam logic [KICK_W-1:0] KICK_MAX = '1;

    typedef struct packed {
        logic [CFG_W-1:0] min_behind;
        logic [CFG_W-1:0] stuck_thr;
        logic [CFG_W-1:0] hard_kicks;
        logic             kick_en;
        logic             telem_en;
    } t_cfg;

    // One registered check, with the state-free distance already worked out
    typedef struct packed {
        logic [SEQ_BITS-1:0] seq;
        logic [SEQ_BITS-1:0] round;
        logic [TIME_W-1:0]   now;
        logic                expect_hint;
        logic [SEQ_BITS-1:0] behind;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    typedef struct packed {
        logic                stuck;
        logic                kick;
        logic                resync;
        logic                report;
        logic [TIME_W-1:0]   stall;
        logic [SEQ_BITS-1:0] behind;
        logic [SEQ_BITS-1:0] advanced;
        logic [KICK_W-1:0]   kick_count;
    } t_result;

endpackage

>>> hdl/psw_req_if.sv
// Request channel of the progress stall watchdog: one periodic check.
// Depends on psw_pkg for field widths.
interface psw_req_if import psw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEQ_FLD_W-1:0] current_seq;
    logic [SEQ_FLD_W-1:0] current_round;
    logic [TIME_W-1:0]    now_seconds;
    logic                 sync_running;
    logic [CACHE_W-1:0]   cached_blocks;
    logic                 is_confidant;

    modport source (
        output valid, current_seq, current_round, now_seconds,
               sync_running, cached_blocks, is_confidant,
        input  ready
    );
    modport sink (
        input  valid, current_seq, current_round, now_seconds,
               sync_running, cached_blocks, is_confidant,
        output ready
    );
endinterface

>>> hdl/psw_rsp_if.sv
// Response channel of the progress stall watchdog: one verdict per check.
// Depends on psw_pkg for field widths.
interface psw_rsp_if import psw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 stuck_detected;
    logic                 kick;
    logic                 force_resync;
    logic                 report_stuck;
    logic [TIME_W-1:0]    stuck_seconds;
    logic [SEQ_FLD_W-1:0] behind_rounds;
    logic [SEQ_FLD_W-1:0] advanced_rounds;
    logic [KICK_W-1:0]    kick_count;

    modport source (
        output valid, stuck_detected, kick, force_resync, report_stuck,
               stuck_seconds, behind_rounds, advanced_rounds, kick_count,
        input  ready
    );
    modport sink (
        input  valid, stuck_detected, kick, force_resync, report_stuck,
               stuck_seconds, behind_rounds, advanced_rounds, kick_count,
        output ready
    );
endinterface

>>> hdl/psw_cfg.sv
// Configuration register file of the progress stall watchdog.
// Depends on psw_pkg for register indexes, reset values and t_cfg.
module psw_cfg import psw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_BEHIND: n_cfg.min_behind = i_cfg_wdata;
                CFG_STUCK_THR:  n_cfg.stuck_thr  = i_cfg_wdata;
                CFG_HARD_KICKS: n_cfg.hard_kicks = i_cfg_wdata;
                CFG_KICK_EN:    n_cfg.kick_en    = i_cfg_wdata[0];
                CFG_TELEM_EN:   n_cfg.telem_en   = i_cfg_wdata[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_behind <= RST_MIN_BEHIND;
            r_cfg.stuck_thr  <= RST_STUCK_THR;
            r_cfg.hard_kicks <= RST_HARD_KICKS;
            r_cfg.kick_en    <= RST_KICK_EN;
            r_cfg.telem_en   <= RST_TELEM_EN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/psw_front.sv
// Input register stage of the progress stall watchdog: captures a check,
// trims it to SEQ_BITS and works out rounds behind. Depends on psw_pkg.
module psw_front import psw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psw_req_if.sink    i_req,
    input  logic       i_pop,
    output t_stage     o_stage
);

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   n_valid;
    logic   take;

    // Accept when empty or when the held check moves on this cycle
    assign i_req.ready = !r_valid || i_pop;
    assign take        = i_req.valid && i_req.ready;

    // Trim the numbers and take the distance to the network round
    always_comb begin
        n_item.seq         = i_req.current_seq[SEQ_BITS-1:0];
        n_item.round       = i_req.current_round[SEQ_BITS-1:0];
        n_item.now         = i_req.now_seconds;
        n_item.expect_hint = i_req.sync_running || (i_req.cached_blocks != '0)
                             || i_req.is_confidant;
        n_item.behind      = (n_item.round > n_item.seq) ?
                             n_item.round - n_item.seq : '0;
        n_valid            = take || (r_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

>>> hdl/psw_judge.sv
// Watchdog state and verdict stage: updates the baseline, judges the stall,
// counts kicks and holds the result register. Depends on psw_pkg.
module psw_judge import psw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_stage   i_stage,
    input  logic     i_out_ready,
    output logic     o_pop,
    output logic     o_out_valid,
    output t_result  o_result
);

    // Watchdog state
    logic                r_primed;
    logic [SEQ_BITS-1:0] r_seen_seq;
    logic [SEQ_BITS-1:0] r_seen_round;
    logic [TIME_W-1:0]   r_change_time;
    logic [KICK_W-1:0]   r_kicks;
    logic                n_primed;
    logic [SEQ_BITS-1:0] n_seen_seq;
    logic [SEQ_BITS-1:0] n_seen_round;
    logic [TIME_W-1:0]   n_change_time;
    logic [KICK_W-1:0]   n_kicks;

    // Result register
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;
    t_result             n_out;

    // Working values
    t_item               it;
    logic                adv_pos;
    logic [SEQ_BITS-1:0] advanced;
    logic                progress;
    logic [TIME_W-1:0]   base_time;
    logic [KICK_W-1:0]   base_kicks;
    logic [KICK_W-1:0]   bumped_kicks;
    logic [TIME_W-1:0]   stall;
    logic                expecting;
    logic                stuck;
    logic                resync;

    assign it    = i_stage.item;
    assign o_pop = i_stage.valid && (!r_out_valid || i_out_ready);

    // Judge the held check against the baseline
    always_comb begin
        adv_pos      = it.round > r_seen_round;
        advanced     = adv_pos ? it.round - r_seen_round : '0;
        progress     = it.seq != r_seen_seq;
        base_time    = progress ? it.now : r_change_time;
        base_kicks   = progress ? '0 : r_kicks;
        stall        = it.now - base_time;
        expecting    = it.expect_hint || adv_pos;
        stuck        = r_primed && expecting
                       && (it.behind >= SEQ_BITS'(i_cfg.min_behind))
                       && (stall >= TIME_W'(i_cfg.stuck_thr));
        bumped_kicks = base_kicks;
        if (stuck && (base_kicks != KICK_MAX)) begin
            bumped_kicks = base_kicks + 1'b1;
        end
        resync       = stuck && i_cfg.kick_en && (bumped_kicks >= i_cfg.hard_kicks);
    end

    // Next state: baseline on the first check, update on later ones
    always_comb begin
        n_primed      = r_primed;
        n_seen_seq    = r_seen_seq;
        n_seen_round  = r_seen_round;
        n_change_time = r_change_time;
        n_kicks       = r_kicks;
        if (o_pop) begin
            n_primed     = 1'b1;
            n_seen_seq   = it.seq;
            n_seen_round = it.round;
            if (!r_primed) begin
                n_change_time = it.now;
                n_kicks       = '0;
            end else begin
                n_change_time = resync ? it.now : base_time;
                n_kicks       = resync ? '0 : bumped_kicks;
            end
        end
    end

    // Assemble the result; a baseline check reports only rounds behind
    always_comb begin
        n_out.stuck      = stuck;
        n_out.kick       = stuck && i_cfg.kick_en;
        n_out.resync     = resync;
        n_out.report     = stuck && i_cfg.telem_en;
        n_out.stall      = r_primed ? stall : '0;
        n_out.behind     = it.behind;
        n_out.advanced   = r_primed ? advanced : '0;
        n_out.kick_count = n_kicks;
        n_out_valid      = o_pop || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed      <= 1'b0;
            r_seen_seq    <= '0;
            r_seen_round  <= '0;
            r_change_time <= '0;
            r_kicks       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_primed      <= n_primed;
            r_seen_seq    <= n_seen_seq;
            r_seen_round  <= n_seen_round;
            r_change_time <= n_change_time;
            r_kicks       <= n_kicks;
            r_out_valid   <= n_out_valid;
        end
    end

    // Load the result register as the check leaves the input stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> hdl/progress_stall_watchdog.sv
// Progress stall watchdog. Takes one periodic check per request and returns
// one verdict per check. A check is taken in every cycle when the result side
// keeps up; its verdict is offered after the check has been held in the input
// register and then moved to the result register, which also lets a new check
// enter while a verdict waits. The first check after reset only sets the
// baseline. Configuration writes are single-cycle and take effect on the next
// check judged; write them only while no check is in flight.
`include "progress_stall_watchdog_assert.svh"

// Top level: config registers, input stage and verdict stage.
// Depends on psw_pkg, psw_req_if, psw_rsp_if, psw_cfg, psw_front, psw_judge.
module progress_stall_watchdog import psw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    psw_req_if.sink              i_req,
    psw_rsp_if.source            o_rsp
);

    t_cfg    cfg;
    t_stage  stage;
    t_result result;
    logic    pop;
    logic    out_valid;

    psw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    psw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_stage (stage)
    );

    psw_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_stage     (stage),
        .i_out_ready (o_rsp.ready),
        .o_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    // Drive the response channel from the result register
    assign o_rsp.valid           = out_valid;
    assign o_rsp.stuck_detected  = result.stuck;
    assign o_rsp.kick            = result.kick;
    assign o_rsp.force_resync    = result.resync;
    assign o_rsp.report_stuck    = result.report;
    assign o_rsp.stuck_seconds   = result.stall;
    assign o_rsp.behind_rounds   = SEQ_FLD_W'(result.behind);
    assign o_rsp.advanced_rounds = SEQ_FLD_W'(result.advanced);
    assign o_rsp.kick_count      = result.kick_count;

    // A forced resync always comes with a kick and a cleared count
    `PSW_ASSERT_SAME(a_resync_kick, i_clk, i_rst_n, out_valid && result.resync, result.kick && (result.kick_count == '0), "resync without kick or with kicks left")

    // Actions only accompany a stuck verdict
    `PSW_ASSERT_SAME(a_act_needs_stuck, i_clk, i_rst_n, out_valid && !result.stuck, !result.kick && !result.resync && !result.report, "action raised without stuck verdict")

    // A check moved on while the result waits would be lost
    `PSW_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, out_valid && !o_rsp.ready, !pop, "check overwrote a waiting result")

    // A check accepted into an empty stage is held for the next cycle
    `PSW_ASSERT_NEXT(a_stage_fill, i_clk, i_rst_n, i_req.valid && i_req.ready, stage.valid, "accepted check missing from input stage")

endmodule
